>>> hw/rtl/sfr_pkg.sv
// Shared types and constants of the streaming find-and-replace block.
`default_nettype none

package sfr_pkg;

  // Longest search pattern and longest replacement text, in bytes.
  localparam int unsigned MaxPattern = 8;
  localparam int unsigned MaxReplace = 8;

  // Entries of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam logic [1:0] CfgSearchPattern   = 2'd0;
  localparam logic [1:0] CfgSearchLength    = 2'd1;
  localparam logic [1:0] CfgReplacementText = 2'd2;
  localparam logic [1:0] CfgReplacementLen  = 2'd3;

  // One input beat as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfr_front.sv
// Front end: accepts input beats and queues them for the matching engine.
`default_nettype none

module sfr_front import sfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_end_i,
  output logic            item_valid_o,
  output item_t           item_o,
  input  wire logic       item_pop_i
);

  item_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 push;
  logic                 pop;

  // The stall depends on the fill level only, never on the upstream valid.
  assign in_stall_o   = (count_q == QueueCntW'(QueueDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = entry_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{data: in_byte_i, last: in_end_i};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sfr_back.sv
// Back end: matching sequencer, configuration registers and output register.
`default_nettype none

module sfr_back import sfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  input  wire item_t       item_i,
  output logic             item_pop_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output result_t          out_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StRepl  = 3'd2;
  localparam logic [2:0] StFlush = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  localparam int unsigned CntW = $clog2(MaxPattern + 1);
  localparam int unsigned IdxW = $clog2(MaxReplace + 1);
  localparam int unsigned PosW = $clog2(MaxPattern);
  localparam int unsigned RepW = $clog2(MaxReplace);

  logic [63:0]     pat_q, rep_q;
  logic [3:0]      slen_q, rlen_q;
  logic [2:0]      state_q, state_d;
  logic [7:0]      hold_q [MaxPattern];
  logic [7:0]      hold_d [MaxPattern];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            end_q, end_d;
  logic            pend_valid_q, pend_valid_d;
  logic [7:0]      pend_byte_q, pend_byte_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic [CntW-1:0] eff_len;
  logic [IdxW-1:0] eff_rlen;
  logic            prefix_ok;
  logic            out_free;
  logic            can_emit;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            push;
  result_t         push_res;

  // A search length of zero acts as one; longer values saturate.
  always_comb begin
    if (slen_q == 4'd0) begin
      eff_len = CntW'(1);
    end else if (slen_q > 4'(MaxPattern)) begin
      eff_len = CntW'(MaxPattern);
    end else begin
      eff_len = CntW'(slen_q);
    end
    eff_rlen = (rlen_q > 4'(MaxReplace)) ? IdxW'(MaxReplace) : IdxW'(rlen_q);
  end

  // The held bytes still form a prefix of the pattern.
  always_comb begin
    prefix_ok = (cnt_q <= eff_len);
    for (int i = 0; i < MaxPattern; i++) begin
      if ((CntW'(i) < cnt_q) && (hold_q[i] != pat_q[8*i +: 8])) begin
        prefix_ok = 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign can_emit = !pend_valid_q || out_free;

  always_comb begin
    state_d      = state_q;
    hold_d       = hold_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    end_d        = end_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    item_pop_o   = 1'b0;
    emit         = 1'b0;
    emit_byte    = '0;
    push         = 1'b0;
    push_res     = '{data: pend_byte_q, present: 1'b1, last: 1'b0};

    unique case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          item_pop_o               = 1'b1;
          hold_d[cnt_q[PosW-1:0]]  = item_i.data;
          cnt_d                    = cnt_q + 1'b1;
          end_d                    = item_i.last;
          state_d                  = StScan;
        end
      end
      StScan: begin
        if ((cnt_q != '0) && !prefix_ok) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_byte = hold_q[0];
            for (int i = 0; i < MaxPattern - 1; i++) begin
              hold_d[i] = hold_q[i+1];
            end
            cnt_d = cnt_q - 1'b1;
          end
        end else if (cnt_q == eff_len) begin
          idx_d   = '0;
          state_d = StRepl;
        end else if (end_q) begin
          state_d = StFlush;
        end else begin
          state_d = StDone;
        end
      end
      StRepl: begin
        if (idx_q < eff_rlen) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_byte = rep_q[8*idx_q[RepW-1:0] +: 8];
            idx_d     = idx_q + 1'b1;
          end
        end else begin
          cnt_d   = '0;
          state_d = end_q ? StFlush : StDone;
        end
      end
      StFlush: begin
        if (cnt_q != '0) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_byte = hold_q[0];
            for (int i = 0; i < MaxPattern - 1; i++) begin
              hold_d[i] = hold_q[i+1];
            end
            cnt_d = cnt_q - 1'b1;
          end
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        // The last beat of a string carries the end mark; with nothing
        // produced for the final item it is an empty marker.
        if (out_free) begin
          push         = 1'b1;
          push_res     = '{data: pend_valid_q ? pend_byte_q : 8'd0,
                           present: pend_valid_q, last: 1'b1};
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      StDone: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          push         = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A new byte goes to the pending slot and pushes the older one out.
    if (emit) begin
      push         = pend_valid_q;
      pend_valid_d = 1'b1;
      pend_byte_d  = emit_byte;
    end

    // A new pattern or length discards the partial match.
    if (cfg_we_i && ((cfg_index_i == CfgSearchPattern) ||
                     (cfg_index_i == CfgSearchLength))) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q        <= '0;
      slen_q       <= 4'd1;
      rep_q        <= '0;
      rlen_q       <= '0;
      state_q      <= StIdle;
      cnt_q        <= '0;
      idx_q        <= '0;
      end_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      end_q        <= end_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgSearchPattern:   pat_q  <= cfg_data_i;
          CfgSearchLength:    slen_q <= cfg_data_i[3:0];
          CfgReplacementText: rep_q  <= cfg_data_i;
          CfgReplacementLen:  rlen_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q      <= hold_d;
    pend_byte_q <= pend_byte_d;
    out_q       <= out_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/stream_find_and_replace.sv
// Top level of the streaming find-and-replace block.
`default_nettype none

// Usage: text enters one byte per beat on the in channel (in_byte_i, with
// in_end_i set on the final byte of a string) and leaves one byte per beat
// on the out channel. Every occurrence of the search pattern is replaced by
// the replacement text, leftmost first and without overlap; inserted text
// is never searched again. out_end_o marks the final beat of a string, and
// when a string ends with nothing left to send, a beat with byte_present_o
// low carries that mark alone.
// Input beats first land in a two-entry queue, so the source can keep
// going while the matching engine is busy. For each beat the engine loads
// it, releases held bytes one at a time on a mismatch, sends the
// replacement bytes, flushes held bytes at the end of a string and then
// closes the item; it takes the next beat from the queue only after that.
// One byte is held back in a pending slot so the end mark can be attached;
// a newer byte pushes it out, and the last byte of an item appears at the
// output once the item is finished.
// A stall on the out channel freezes the output register and, once the
// pending slot is full, the engine; the queue then fills and stalls the in
// channel. Reset empties the queue and the partial match and restores the
// default configuration. Writes to the search pattern or its length drop a
// partial match; configure only while the block is idle.
module stream_find_and_replace import sfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_present_o,
  output logic             out_end_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic    item_valid;
  item_t   item;
  logic    item_pop;
  result_t result;

  // The front end only buffers; all matching state lives in the back end.
  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_end_i     (in_end_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  sfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (result)
  );

  assign out_byte_o     = result.data;
  assign byte_present_o = result.present;
  assign out_end_o      = result.last;

endmodule

`default_nettype wire
